// ----- hdl/bvs_pkg.sv -----
package bvs_pkg;

   // Widths
   localparam int COORD_BITS = 12;
   localparam int CONF_W     = 10;
   localparam int MODE_W     = 2;
   localparam int SPD_W      = 11;
   localparam int YAW_W      = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = (COORD_BITS > CONF_W) ? COORD_BITS : CONF_W;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [COORD_BITS:0]   diff_type;
   typedef logic [CONF_W-1:0]            conf_type;
   typedef logic [MODE_W-1:0]            mode_type;
   typedef logic signed [SPD_W-1:0]      spd_type;
   typedef logic signed [YAW_W-1:0]      yaw_type;
   typedef logic [CSR_IDX_W-1:0]         csr_idx_type;
   typedef logic [CSR_W-1:0]             csr_data_type;

   // Register indexes
   localparam csr_idx_type REG_FRAME_CENTER_X         = 2'd0;
   localparam csr_idx_type REG_FRAME_CENTER_Y         = 2'd1;
   localparam csr_idx_type REG_TRACK_MIN_CONFIDENCE   = 2'd2;
   localparam csr_idx_type REG_SELFCAM_MIN_CONFIDENCE = 2'd3;

   // Register reset values
   localparam coord_type RST_FRAME_CENTER_X = COORD_BITS'(428);
   localparam coord_type RST_FRAME_CENTER_Y = COORD_BITS'(240);
   localparam conf_type  RST_TRACK_CONF     = CONF_W'(650);
   localparam conf_type  RST_SELFCAM_CONF   = CONF_W'(550);

   // Mode bits
   localparam int MODE_TRACK_BIT   = 0;
   localparam int MODE_SELFCAM_BIT = 1;

   localparam int YAW_LIMIT = 10240;

   typedef struct packed {
      coord_type fcx;
      coord_type fcy;
      conf_type  trk_conf;
      conf_type  cam_conf;
   } bvs_cfg_type;

   typedef struct packed {
      mode_type  mode;
      conf_type  confidence;
      coord_type x_min;
      coord_type x_max;
      coord_type y_min;
      coord_type y_max;
   } bvs_item_type;

   typedef struct packed {
      spd_type forward_speed;
      spd_type lateral_speed;
      spd_type vertical_speed;
      yaw_type yaw_rate;
   } bvs_cmd_type;

   // Signed box height, negative for an inverted box
   function automatic diff_type box_height(input coord_type y_lo, input coord_type y_hi);
      box_height = $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
   endfunction

endpackage

// ----- hdl/bvs_if.sv -----
interface bvs_req_if;
   logic                valid;
   logic                ready;
   bvs_pkg::mode_type   mode;
   bvs_pkg::conf_type   confidence;
   bvs_pkg::coord_type  x_min;
   bvs_pkg::coord_type  x_max;
   bvs_pkg::coord_type  y_min;
   bvs_pkg::coord_type  y_max;

   modport source (output valid, mode, confidence, x_min, x_max, y_min, y_max,
                   input ready);
   modport sink   (input valid, mode, confidence, x_min, x_max, y_min, y_max,
                   output ready);
endinterface

interface bvs_rsp_if;
   logic               valid;
   logic               ready;
   bvs_pkg::spd_type   forward_speed;
   bvs_pkg::spd_type   lateral_speed;
   bvs_pkg::spd_type   vertical_speed;
   bvs_pkg::yaw_type   yaw_rate;

   modport source (output valid, forward_speed, lateral_speed, vertical_speed, yaw_rate,
                   input ready);
   modport sink   (input valid, forward_speed, lateral_speed, vertical_speed, yaw_rate,
                   output ready);
endinterface

// ----- hdl/bvs_csr.sv -----
module bvs_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  bvs_pkg::csr_idx_type   csr_index,
   input  bvs_pkg::csr_data_type  csr_wdata,
   output bvs_pkg::bvs_cfg_type   cfg
);
   import bvs_pkg::*;

   bvs_cfg_type cfg_ff, cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_CENTER_X:         cfg_in.fcx      = csr_wdata[COORD_BITS-1:0];
            REG_FRAME_CENTER_Y:         cfg_in.fcy      = csr_wdata[COORD_BITS-1:0];
            REG_TRACK_MIN_CONFIDENCE:   cfg_in.trk_conf = csr_wdata[CONF_W-1:0];
            REG_SELFCAM_MIN_CONFIDENCE: cfg_in.cam_conf = csr_wdata[CONF_W-1:0];
            default:                    cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fcx      <= RST_FRAME_CENTER_X;
         cfg_ff.fcy      <= RST_FRAME_CENTER_Y;
         cfg_ff.trk_conf <= RST_TRACK_CONF;
         cfg_ff.cam_conf <= RST_SELFCAM_CONF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/bvs_track.sv -----
module bvs_track (
   input  bvs_pkg::bvs_item_type  item,
   input  bvs_pkg::bvs_cfg_type   cfg,
   output bvs_pkg::bvs_cmd_type   cmd
);
   import bvs_pkg::*;

   localparam yaw_type YAW_HI  = 15'sd350;
   localparam yaw_type YAW_MID = 15'sd200;
   localparam yaw_type YAW_LO  = 15'sd100;
   localparam spd_type FWD_BACK = -11'sd100;

   logic [COORD_BITS:0]          sum_x, sum_y;
   coord_type                    xmid, ymid, adx;
   diff_type                     dx, h;
   logic signed [COORD_BITS+1:0] ymid_s, fcy_hi, fcy_lo;
   yaw_type                      yaw_tier, addend;
   spd_type                      base, side, nudge, trim, vmag;
   logic                         step_left, step_right;

   // Box centre and offsets
   assign sum_x  = {1'b0, item.x_min} + {1'b0, item.x_max};
   assign sum_y  = {1'b0, item.y_min} + {1'b0, item.y_max};
   assign xmid   = sum_x[COORD_BITS:1];
   assign ymid   = sum_y[COORD_BITS:1];
   assign dx     = $signed({1'b0, xmid}) - $signed({1'b0, cfg.fcx});
   assign adx    = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
   assign h      = box_height(item.y_min, item.y_max);
   assign ymid_s = $signed({2'b00, ymid});
   assign fcy_hi = $signed({2'b00, cfg.fcy}) + 14'sd15;
   assign fcy_lo = $signed({2'b00, cfg.fcy}) - 14'sd15;

   // Yaw tier from the horizontal offset
   always_comb begin
      yaw_tier = '0;
      priority if (adx > 130) yaw_tier = (dx > 0) ? -YAW_HI  : YAW_HI;
      else if (adx > 80)      yaw_tier = (dx > 0) ? -YAW_MID : YAW_MID;
      else if (adx > 30)      yaw_tier = (dx > 0) ? -YAW_LO  : YAW_LO;
      else                    yaw_tier = '0;
   end

   // Pick the height tier constants
   always_comb begin
      priority if (h < 150) begin
         base = 11'sd230; side = 11'sd60; nudge = 11'sd80;
         trim = 11'sd180; addend = -15'sd130; vmag = 11'sd280;
      end else if (h < 250) begin
         base = 11'sd180; side = 11'sd35; nudge = 11'sd30;
         trim = 11'sd130; addend = -15'sd100; vmag = 11'sd200;
      end else begin
         base = 11'sd100; side = 11'sd10; nudge = 11'sd10;
         trim = 11'sd30;  addend = -15'sd70;  vmag = 11'sd50;
      end
   end

   assign step_left  = dx > side;
   assign step_right = dx < -side;

   // Build the command
   always_comb begin
      cmd = '0;
      cmd.yaw_rate = yaw_tier;
      priority if (h < 290) begin
         cmd.forward_speed = base;
         if (step_left || step_right) begin
            cmd.lateral_speed = step_left ? -nudge : nudge;
            cmd.forward_speed = base - trim;
            cmd.yaw_rate      = yaw_tier + addend;
         end
         if (ymid_s > fcy_hi)      cmd.vertical_speed = -vmag;
         else if (ymid_s < fcy_lo) cmd.vertical_speed = vmag;
      end else if (h < 325) begin
         cmd.forward_speed = '0;
      end else begin
         cmd.forward_speed = FWD_BACK;
      end
   end

endmodule

// ----- hdl/bvs_selfcam.sv -----
module bvs_selfcam (
   input  bvs_pkg::bvs_item_type  item,
   input  bvs_pkg::bvs_cfg_type   cfg,
   input  bvs_pkg::coord_type     ref_height,
   output bvs_pkg::bvs_cmd_type   cmd
);
   import bvs_pkg::*;

   localparam logic [COORD_BITS+2:0] MAG_LIMIT = (COORD_BITS+3)'(YAW_LIMIT);

   diff_type                     h, w, w_adj, half_w;
   logic signed [COORD_BITS+1:0] mx, xgap, gap;
   logic [COORD_BITS:0]          ag;
   logic [COORD_BITS+3:0]        mag5;
   logic [COORD_BITS+2:0]        mag, mag_sat;

   // Box centre, truncating half the width toward zero
   assign h      = box_height(item.y_min, item.y_max);
   assign w      = $signed({1'b0, item.x_max}) - $signed({1'b0, item.x_min});
   assign w_adj  = w + $signed({{COORD_BITS{1'b0}}, w[COORD_BITS]});
   assign half_w = w_adj >>> 1;
   assign mx     = half_w + $signed({2'b00, item.x_min});
   assign xgap   = $signed({2'b00, cfg.fcx}) - mx;
   assign ag     = xgap[COORD_BITS+1] ? (COORD_BITS+1)'(-xgap) : (COORD_BITS+1)'(xgap);

   // Yaw is 2.5 times the offset, saturated
   assign mag5    = {1'b0, ag, 2'b00} + {3'b000, ag};
   assign mag     = mag5[COORD_BITS+3:1];
   assign mag_sat = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;

   assign gap = $signed({2'b00, ref_height}) - h;

   always_comb begin
      cmd = '0;
      if (ag > 25) begin
         cmd.yaw_rate = xgap[COORD_BITS+1] ? -YAW_W'(mag_sat) : YAW_W'(mag_sat);
      end
      priority if (gap > 30) begin
         cmd.forward_speed = 11'sd80;
         cmd.lateral_speed = 11'sd80;
      end else if (gap < -30) begin
         cmd.forward_speed = -11'sd80;
         cmd.lateral_speed = 11'sd80;
      end else begin
         cmd.forward_speed = 11'sd90;
         cmd.lateral_speed = 11'sd110;
      end
   end

endmodule

// ----- hdl/bbox_visual_servo_command.sv -----
// Each item is registered in the input register and its result in the result register,
// which drives rsp_chan. Throughput: one item per cycle while rsp_chan takes the results;
// a result held by rsp_chan stalls the input register and then req_chan.ready.
// Items with a low confidence or idle mode give no result.
// Reset (synchronous, active high) empties both stages, drops the height
// reference and loads the configuration registers with their defaults.
module bbox_visual_servo_command (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  bvs_pkg::csr_idx_type   csr_index,
   input  bvs_pkg::csr_data_type  csr_wdata,
   bvs_req_if.sink                req_chan,
   bvs_rsp_if.source              rsp_chan
);
   import bvs_pkg::*;

   bvs_cfg_type  cfg;
   bvs_item_type s1_item_ff, s1_item_in;
   logic         s1_valid_ff, s1_valid_in;
   bvs_cmd_type  rsp_cmd_ff, rsp_cmd_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         have_ref_ff, have_ref_in;
   coord_type    ref_h_ff, ref_h_in;
   bvs_cmd_type  trk_cmd, cam_cmd;
   diff_type     s1_h;
   coord_type    h_clamped, ref_eff;
   logic         is_track, is_selfcam, trk_fire, cam_fire;
   logic         rsp_free, s1_go, req_take;

   bvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Capture the input item
   always_comb begin
      s1_item_in            = s1_item_ff;
      s1_valid_in           = s1_valid_ff;
      if (req_take) begin
         s1_item_in.mode       = req_chan.mode;
         s1_item_in.confidence = req_chan.confidence;
         s1_item_in.x_min      = req_chan.x_min;
         s1_item_in.x_max      = req_chan.x_max;
         s1_item_in.y_min      = req_chan.y_min;
         s1_item_in.y_max      = req_chan.y_max;
         s1_valid_in           = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Mode decode; tracking wins over self-camera
   assign is_track   = s1_item_ff.mode[MODE_TRACK_BIT];
   assign is_selfcam = !is_track && s1_item_ff.mode[MODE_SELFCAM_BIT];
   assign trk_fire   = is_track && (s1_item_ff.confidence >= cfg.trk_conf);
   assign cam_fire   = is_selfcam && (s1_item_ff.confidence >= cfg.cam_conf);

   // Latch the height reference on the first self-camera item of a run; any other item drops it
   assign s1_h      = box_height(s1_item_ff.y_min, s1_item_ff.y_max);
   assign h_clamped = s1_h[COORD_BITS] ? '0 : s1_h[COORD_BITS-1:0];
   assign ref_eff   = have_ref_ff ? ref_h_ff : h_clamped;

   always_comb begin
      have_ref_in = have_ref_ff;
      ref_h_in    = ref_h_ff;
      if (s1_go) begin
         have_ref_in = is_selfcam;
         if (is_selfcam && !have_ref_ff) ref_h_in = h_clamped;
      end
   end

   bvs_track u_track (
      .item (s1_item_ff),
      .cfg  (cfg),
      .cmd  (trk_cmd)
   );

   bvs_selfcam u_selfcam (
      .item       (s1_item_ff),
      .cfg        (cfg),
      .ref_height (ref_eff),
      .cmd        (cam_cmd)
   );

   // Load or drain the result register
   always_comb begin
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = trk_fire || cam_fire;
         rsp_cmd_in   = trk_fire ? trk_cmd : cam_cmd;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_ref_ff  <= 1'b0;
         ref_h_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ref_ff  <= have_ref_in;
         ref_h_ff     <= ref_h_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_cmd_ff <= rsp_cmd_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.forward_speed  = rsp_cmd_ff.forward_speed;
   assign rsp_chan.lateral_speed  = rsp_cmd_ff.lateral_speed;
   assign rsp_chan.vertical_speed = rsp_cmd_ff.vertical_speed;
   assign rsp_chan.yaw_rate       = rsp_cmd_ff.yaw_rate;

endmodule
